// ===== rtl/tps_pkg.sv =====
// tps_pkg: widths, pipeline shape and prescaler codes for the tone prescaler select unit.
// No dependencies.

package tps_pkg;

  localparam int unsigned CLK_W     = 25;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned CMP_W     = 8;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned QUO_W     = CLK_W - 1;

  // restoring divider: DIV_STAGES stages of DIV_STEPS quotient bits each
  localparam int unsigned DIV_STEPS  = 5;
  localparam int unsigned DIV_STAGES = (CLK_W + DIV_STEPS - 1) / DIV_STEPS;

  localparam logic [QUO_W-1:0] STEP_LIMIT = QUO_W'(256);
  localparam logic [QUO_W-1:0] CMP_MAX    = QUO_W'(255);

  typedef enum logic [CODE_W-1:0] {
    PRESC_OFF     = 3'd0,
    PRESC_DIV1    = 3'd1,
    PRESC_DIV8    = 3'd2,
    PRESC_DIV64   = 3'd3,
    PRESC_DIV256  = 3'd4,
    PRESC_DIV1024 = 3'd5
  } presc_code_t;

  localparam logic [CODE_W-1:0] CODE_OFF  = PRESC_OFF;
  localparam logic [CODE_W-1:0] CODE_DIV1 = PRESC_DIV1;

endpackage

// ===== rtl/tone_prescaler_select_unit.sv =====
// tone_prescaler_select_unit: pipelined frequency to timer prescaler/compare selection.
// Depends on tps_pkg.
//
// Usage:
//   Input: drive in_wanted_freq with start high; a beat is taken at each rising edge
//   where start is high and busy is low. busy is always low, so one request can be
//   taken every cycle.
//   Output: out_valid pulses for one cycle with out_compare_value, out_prescale_code
//   and out_out_of_range. Results come back in request order, registered through
//   1 capture stage, 5 divider stages of 5 quotient bits each and
//   2 prescaler/clamp stages. Throughput is one result per cycle; the divider
//   stages perform the 25-step restoring divide that forms clock_hz / wanted_freq.
//   The receiver cannot stall; every result is shown for exactly one cycle.
//   Config: APB register 0 (address 0) is clock_hz, 25 bits, reset value 4195200.
//   Write it only while no requests are in flight; each request uses the value
//   present at its accepting edge. Reads return the register.
//   Reset (rst_n low, synchronous): all in-flight beats are dropped, clock_hz
//   returns to its reset value. A frequency of zero yields the off code.

module tone_prescaler_select_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      start,
  output logic                      busy,
  input  logic [tps_pkg::FREQ_W-1:0] in_wanted_freq,
  // result channel
  output logic                      out_valid,
  output logic [tps_pkg::CMP_W-1:0]  out_compare_value,
  output logic [tps_pkg::CODE_W-1:0] out_prescale_code,
  output logic                      out_out_of_range,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned NSTG    = tps_pkg::DIV_STAGES;
  localparam int unsigned LATENCY = NSTG + 3;

  // ---------------------------------------------------------------- config
  logic [tps_pkg::CLK_W-1:0] clock_hz_r;
  logic [tps_pkg::CLK_W-1:0] clock_hz_nxt;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = {{(32 - tps_pkg::CLK_W){1'b0}}, clock_hz_r};

  always_comb begin
    clock_hz_nxt = clock_hz_r;
    if (cfg_wr) begin
      clock_hz_nxt = pwdata[tps_pkg::CLK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= tps_pkg::CLK_W'(4195200);
    end else begin
      clock_hz_r <= clock_hz_nxt;
    end
  end

  // ---------------------------------------------------------------- divider
  assign busy = 1'b0;

  logic                           vld_r [NSTG+1];
  logic                           off_r [NSTG+1];
  logic [tps_pkg::FREQ_W-1:0]     rem_r [NSTG+1];
  logic [tps_pkg::CLK_W-1:0]      num_r [NSTG+1];
  logic [tps_pkg::FREQ_W-1:0]     dvs_r [NSTG+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
    end
    off_r[0] <= (in_wanted_freq == '0);
    rem_r[0] <= '0;
    num_r[0] <= clock_hz_r;
    dvs_r[0] <= in_wanted_freq;
  end

  for (genvar s = 1; s <= NSTG; s++) begin : g_div
    logic [tps_pkg::FREQ_W-1:0] rem_nxt;
    logic [tps_pkg::CLK_W-1:0]  num_nxt;

    always_comb begin
      logic [tps_pkg::FREQ_W:0] trial;
      logic [tps_pkg::FREQ_W:0] diff;
      rem_nxt = rem_r[s-1];
      num_nxt = num_r[s-1];
      for (int j = 0; j < int'(tps_pkg::DIV_STEPS); j++) begin
        trial   = {rem_nxt, num_nxt[tps_pkg::CLK_W-1]};
        num_nxt = {num_nxt[tps_pkg::CLK_W-2:0], 1'b0};
        diff    = trial - {1'b0, dvs_r[s-1]};
        if (trial >= {1'b0, dvs_r[s-1]}) begin
          rem_nxt    = diff[tps_pkg::FREQ_W-1:0];
          num_nxt[0] = 1'b1;
        end else begin
          rem_nxt = trial[tps_pkg::FREQ_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
      off_r[s] <= off_r[s-1];
      rem_r[s] <= rem_nxt;
      num_r[s] <= num_nxt;
      dvs_r[s] <= dvs_r[s-1];
    end
  end

  // ---------------------------------------------------------------- prescaler steps
  // q = floor(clock/f) / 2; first two steps divide by 8
  logic                        pa_vld_r;
  logic                        pa_off_r;
  logic [tps_pkg::QUO_W-1:0]   pa_q_r;
  logic [tps_pkg::CODE_W-1:0]  pa_code_r;
  logic [tps_pkg::QUO_W-1:0]   pa_q_nxt;
  logic [tps_pkg::CODE_W-1:0]  pa_code_nxt;

  always_comb begin
    pa_q_nxt    = num_r[NSTG][tps_pkg::CLK_W-1:1];
    pa_code_nxt = tps_pkg::CODE_DIV1;
    for (int k = 0; k < 2; k++) begin
      if (pa_q_nxt > tps_pkg::STEP_LIMIT) begin
        pa_q_nxt    = pa_q_nxt >> 3;
        pa_code_nxt = pa_code_nxt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_vld_r <= 1'b0;
    end else begin
      pa_vld_r <= vld_r[NSTG];
    end
    pa_off_r  <= off_r[NSTG];
    pa_q_r    <= pa_q_nxt;
    pa_code_r <= pa_code_nxt;
  end

  // last two steps divide by 4, then clamp q - 1 to 0..255
  logic                        out_valid_r;
  logic [tps_pkg::CMP_W-1:0]   cmp_r;
  logic [tps_pkg::CODE_W-1:0]  code_r;
  logic                        oor_r;
  logic [tps_pkg::CMP_W-1:0]   cmp_nxt;
  logic [tps_pkg::CODE_W-1:0]  code_nxt;
  logic                        oor_nxt;

  always_comb begin
    logic [tps_pkg::QUO_W-1:0] q;
    logic [tps_pkg::QUO_W-1:0] qm1;
    q        = pa_q_r;
    code_nxt = pa_code_r;
    for (int k = 0; k < 2; k++) begin
      if (q > tps_pkg::STEP_LIMIT) begin
        q        = q >> 2;
        code_nxt = code_nxt + 3'd1;
      end
    end
    qm1 = q - tps_pkg::QUO_W'(1);
    if (pa_off_r) begin
      cmp_nxt  = '0;
      code_nxt = tps_pkg::CODE_OFF;
      oor_nxt  = 1'b0;
    end else if (q == '0) begin
      cmp_nxt = '0;
      oor_nxt = 1'b1;
    end else if (qm1 > tps_pkg::CMP_MAX) begin
      cmp_nxt = '1;
      oor_nxt = 1'b1;
    end else begin
      cmp_nxt = qm1[tps_pkg::CMP_W-1:0];
      oor_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pa_vld_r;
    end
    cmp_r  <= cmp_nxt;
    code_r <= code_nxt;
    oor_r  <= oor_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_compare_value = cmp_r;
  assign out_prescale_code = code_r;
  assign out_out_of_range  = oor_r;

  // ---------------------------------------------------------------- assertions
`ifndef ASSERT_OFF
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted beat did not produce a result");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LATENCY))
    else $error("result without a matching request");

  a_clamp_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_compare_value == '0 || out_compare_value == '1))
    else $error("flagged result not at a clamp limit");

  a_off_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_prescale_code == tps_pkg::CODE_OFF) |->
      (out_compare_value == '0 && !out_out_of_range))
    else $error("off code with nonzero compare or flag");
`endif

endmodule
